### design/phs_pkg.sv
// shared types, constants and register codes for the pose history smoother
`timescale 1ns / 1ps

package phs_pkg;

  // pose component width used when the top level is not overridden
  localparam int VALUE_WIDTH_DEF = 24;

  // smoothing window and pose layout
  localparam int HIST_LEN  = 5;
  localparam int NUM_COMPS = 6;

  // configuration register widths
  localparam int WEIGHT_W   = 16;
  localparam int LIMIT_W    = 23;
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 23;

  // register reset values
  localparam logic [WEIGHT_W-1:0] W_OLDEST_RST = 16'd3277;
  localparam logic [WEIGHT_W-1:0] W_SECOND_RST = 16'd3277;
  localparam logic [WEIGHT_W-1:0] W_MIDDLE_RST = 16'd6554;
  localparam logic [WEIGHT_W-1:0] W_FOURTH_RST = 16'd19661;
  localparam logic [WEIGHT_W-1:0] W_NEWEST_RST = 16'd32768;
  localparam logic [LIMIT_W-1:0]  LIMIT_RST    = 23'd2621;

  // register indexes on the configuration port
  typedef enum logic [CFG_ADDR_W-1:0] {
    REG_W_OLDEST = 3'd0,
    REG_W_SECOND = 3'd1,
    REG_W_MIDDLE = 3'd2,
    REG_W_FOURTH = 3'd3,
    REG_W_NEWEST = 3'd4,
    REG_LIMIT    = 3'd5
  } reg_idx_t;

  // what happened to a beat
  typedef enum logic [1:0] {
    OUTCOME_PASS    = 2'd0,
    OUTCOME_SMOOTH  = 2'd1,
    OUTCOME_OUTLIER = 2'd2
  } outcome_t;

  // live configuration, weights oldest first
  typedef struct packed {
    logic [HIST_LEN-1:0][WEIGHT_W-1:0] weights;
    logic [LIMIT_W-1:0]                limit;
  } cfg_t;

  // history update request from the datapath
  typedef struct packed {
    logic commit;    // a sole detection leaves the input register
    logic in_bound;  // all six deviations under the limit
  } hist_ctrl_t;

endpackage

### design/phs_cfg.sv
// configuration registers: five window weights and the deviation limit
`timescale 1ns / 1ps

module phs_cfg (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_valid,
  input  logic                              cfg_ready,
  input  logic [phs_pkg::CFG_ADDR_W-1:0]    cfg_addr,
  input  logic [phs_pkg::CFG_DATA_W-1:0]    cfg_data,
  output phs_pkg::cfg_t                     cfg
);

  phs_pkg::cfg_t cfg_r;
  phs_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_valid && cfg_ready) begin
      case (phs_pkg::reg_idx_t'(cfg_addr))
        phs_pkg::REG_W_OLDEST: cfg_nxt.weights[0] = cfg_data[phs_pkg::WEIGHT_W-1:0];
        phs_pkg::REG_W_SECOND: cfg_nxt.weights[1] = cfg_data[phs_pkg::WEIGHT_W-1:0];
        phs_pkg::REG_W_MIDDLE: cfg_nxt.weights[2] = cfg_data[phs_pkg::WEIGHT_W-1:0];
        phs_pkg::REG_W_FOURTH: cfg_nxt.weights[3] = cfg_data[phs_pkg::WEIGHT_W-1:0];
        phs_pkg::REG_W_NEWEST: cfg_nxt.weights[4] = cfg_data[phs_pkg::WEIGHT_W-1:0];
        phs_pkg::REG_LIMIT:    cfg_nxt.limit      = cfg_data[phs_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.weights[0] <= phs_pkg::W_OLDEST_RST;
      cfg_r.weights[1] <= phs_pkg::W_SECOND_RST;
      cfg_r.weights[2] <= phs_pkg::W_MIDDLE_RST;
      cfg_r.weights[3] <= phs_pkg::W_FOURTH_RST;
      cfg_r.weights[4] <= phs_pkg::W_NEWEST_RST;
      cfg_r.limit      <= phs_pkg::LIMIT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

### design/phs_avg.sv
// one pose component: weighted window sum, round, saturate, deviation test
`timescale 1ns / 1ps

module phs_avg #(
  parameter int VALUE_WIDTH = phs_pkg::VALUE_WIDTH_DEF
) (
  input  logic [phs_pkg::HIST_LEN-1:0][VALUE_WIDTH-1:0] win,
  input  logic [phs_pkg::HIST_LEN-1:0][phs_pkg::WEIGHT_W-1:0] weights,
  input  logic [phs_pkg::LIMIT_W-1:0]                    limit,
  input  logic signed [VALUE_WIDTH-1:0]                  sample,
  output logic signed [VALUE_WIDTH-1:0]                  avg,
  output logic                                           in_bound
);

  localparam int PROD_W = VALUE_WIDTH + phs_pkg::WEIGHT_W + 1;
  localparam int ACC_W  = PROD_W + 3;
  localparam int AVG_W  = ACC_W - phs_pkg::WEIGHT_W;
  localparam int DIFF_W = VALUE_WIDTH + 1;
  localparam int CMP_W  = (DIFF_W > phs_pkg::LIMIT_W) ? DIFF_W : phs_pkg::LIMIT_W;

  localparam logic signed [ACC_W-1:0] RND_HALF = ACC_W'(1) << (phs_pkg::WEIGHT_W - 1);
  localparam logic signed [VALUE_WIDTH-1:0] VMAX = {1'b0, {(VALUE_WIDTH-1){1'b1}}};
  localparam logic signed [VALUE_WIDTH-1:0] VMIN = {1'b1, {(VALUE_WIDTH-1){1'b0}}};

  logic signed [PROD_W-1:0] prod [phs_pkg::HIST_LEN];
  logic signed [ACC_W-1:0]  acc;
  logic signed [ACC_W-1:0]  acc_rnd;
  logic signed [AVG_W-1:0]  avg_wide;
  logic signed [DIFF_W-1:0] diff;
  logic        [DIFF_W-1:0] diff_abs;

  // one product per window entry, weight taken as unsigned
  always_comb begin
    for (int e = 0; e < phs_pkg::HIST_LEN; e++) begin
      prod[e] = PROD_W'($signed(win[e])) * $signed(PROD_W'(weights[e]));
    end
  end

  always_comb begin
    acc = '0;
    for (int e = 0; e < phs_pkg::HIST_LEN; e++) begin
      acc = acc + ACC_W'(prod[e]);
    end
    // round half up, then drop the weight fraction
    acc_rnd  = acc + RND_HALF;
    avg_wide = AVG_W'(acc_rnd >>> phs_pkg::WEIGHT_W);
    if (avg_wide > AVG_W'(VMAX)) begin
      avg = VMAX;
    end else if (avg_wide < AVG_W'(VMIN)) begin
      avg = VMIN;
    end else begin
      avg = VALUE_WIDTH'(avg_wide);
    end
    diff     = DIFF_W'(avg) - DIFF_W'(sample);
    diff_abs = diff[DIFF_W-1] ? DIFF_W'(-diff) : DIFF_W'(diff);
    in_bound = CMP_W'(diff_abs) < CMP_W'(limit);
  end

endmodule

### design/phs_history.sv
// raw pose history: five entries of six components and the full flag
`timescale 1ns / 1ps

module phs_history #(
  parameter int VALUE_WIDTH = phs_pkg::VALUE_WIDTH_DEF
) (
  input  logic                                                 clk,
  input  logic                                                 rst_n,
  input  phs_pkg::hist_ctrl_t                                  ctl,
  input  logic [phs_pkg::NUM_COMPS-1:0][VALUE_WIDTH-1:0]       sample,
  output logic [phs_pkg::HIST_LEN-1:0][phs_pkg::NUM_COMPS-1:0][VALUE_WIDTH-1:0] window
);

  logic [phs_pkg::HIST_LEN-1:0][phs_pkg::NUM_COMPS-1:0][VALUE_WIDTH-1:0] hist_r;
  logic full_r;
  logic full_nxt;

  // window after the push: shifted history, or the sample everywhere when empty
  for (genvar e = 0; e < phs_pkg::HIST_LEN; e++) begin : g_win
    if (e < phs_pkg::HIST_LEN - 1) begin : g_old
      assign window[e] = full_r ? hist_r[e+1] : sample;
    end else begin : g_new
      assign window[e] = sample;
    end
  end

  // entries hold data only while full is set
  always_ff @(posedge clk) begin
    if (ctl.commit) begin
      hist_r <= window;
    end
  end

  // an outlier empties the history
  assign full_nxt = ctl.commit ? ctl.in_bound : full_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else begin
      full_r <= full_nxt;
    end
  end

`ifndef NO_ASSERTIONS
  a_outlier_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.commit && !ctl.in_bound) |=> !full_r)
    else $error("history still full after an outlier");

  a_smooth_fills: assert property (@(posedge clk) disable iff (!rst_n)
    (ctl.commit && ctl.in_bound) |=> full_r)
    else $error("history not full after a smoothed beat");

  a_empty_window: assert property (@(posedge clk) disable iff (!rst_n)
    !full_r |-> (window[0] === sample && window[phs_pkg::HIST_LEN-1] === sample))
    else $error("empty history does not present the sample");

  a_idle_holds: assert property (@(posedge clk) disable iff (!rst_n)
    !ctl.commit |=> $stable(full_r))
    else $error("full flag moved without a commit");
`endif

endmodule

### design/pose_history_smoother.sv
// top level of the pose history smoother: handshakes, input and result registers
`timescale 1ns / 1ps

// channel  dir  handshake                 payload
// in_      in   in_tvalid / in_tready     tdata: rot_x..move_z, tuser: sole_detection
// out_     out  out_tvalid / out_tready   tdata: out_rot_x..out_move_z, tuser: outcome
// cfg_     in   cfg_valid / cfg_ready     cfg_addr register index, cfg_data value
//
// a beat taken sits in the input register; the six weighted sums and deviation
// tests settle into the result register once it is free, and out_tvalid then rises
// one beat per cycle sustained while out_tready stays high; the history and full
// flag update when a sole-detection beat moves into the result register, so the
// next beat sees them at once
// rst_n is synchronous, active low; it clears valid flags, full flag and config registers
// a stalled result holds the input register, in_tready drops once it is full; cfg_ready is always high

module pose_history_smoother #(
  parameter  int VALUE_WIDTH = phs_pkg::VALUE_WIDTH_DEF,
  localparam int TDATA_W     = ((phs_pkg::NUM_COMPS * VALUE_WIDTH + 7) / 8) * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  // input beat
  input  logic                           in_tvalid,
  output logic                           in_tready,
  input  logic [TDATA_W-1:0]             in_tdata,   // rot_x, rot_y, rot_z, move_x, move_y, move_z
  input  logic                           in_tuser,   // sole_detection
  // result beat
  output logic                           out_tvalid,
  input  logic                           out_tready,
  output logic [TDATA_W-1:0]             out_tdata,  // out_rot_x .. out_move_z, zero pad on top
  output phs_pkg::outcome_t              out_tuser,  // outcome
  // configuration writes
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [phs_pkg::CFG_ADDR_W-1:0] cfg_addr,
  input  logic [phs_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int POSE_W = phs_pkg::NUM_COMPS * VALUE_WIDTH;

  typedef logic [phs_pkg::NUM_COMPS-1:0][VALUE_WIDTH-1:0] pose_t;

  phs_pkg::cfg_t cfg;

  // input register
  logic  s1_valid_r;
  logic  s1_valid_nxt;
  logic  s1_sole_r;
  pose_t s1_pose_r;

  // result register
  logic              out_valid_r;
  logic              out_valid_nxt;
  pose_t             out_pose_r;
  pose_t             out_pose_nxt;
  phs_pkg::outcome_t out_outcome_r;
  phs_pkg::outcome_t out_outcome_nxt;

  logic in_beat;
  logic adv;

  logic [phs_pkg::HIST_LEN-1:0][phs_pkg::NUM_COMPS-1:0][VALUE_WIDTH-1:0] window;
  pose_t                          avg;
  logic [phs_pkg::NUM_COMPS-1:0]  comp_in_bound;
  logic                           all_in_bound;
  phs_pkg::hist_ctrl_t            hctl;

  // configuration never stalls
  assign cfg_ready = 1'b1;

  phs_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_addr (cfg_addr),
    .cfg_data (cfg_data),
    .cfg      (cfg)
  );

  // handshakes: the input register moves whenever the result register is free
  assign adv       = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || adv;
  assign in_beat   = in_tvalid && in_tready;

  assign s1_valid_nxt  = in_beat ? 1'b1 : (adv ? 1'b0 : s1_valid_r);
  assign out_valid_nxt = adv ? 1'b1 : (out_tready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_beat) begin
      s1_sole_r <= in_tuser;
      s1_pose_r <= pose_t'(in_tdata[POSE_W-1:0]);
    end
  end

  // history sees the current beat only when it is a sole detection
  assign hctl.commit   = adv && s1_sole_r;
  assign hctl.in_bound = all_in_bound;

  phs_history #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_history (
    .clk   (clk),
    .rst_n (rst_n),
    .ctl   (hctl),
    .sample(s1_pose_r),
    .window(window)
  );

  // one averaging lane per pose component
  for (genvar c = 0; c < phs_pkg::NUM_COMPS; c++) begin : g_lane
    logic [phs_pkg::HIST_LEN-1:0][VALUE_WIDTH-1:0] lane_win;

    for (genvar e = 0; e < phs_pkg::HIST_LEN; e++) begin : g_tap
      assign lane_win[e] = window[e][c];
    end

    phs_avg #(
      .VALUE_WIDTH(VALUE_WIDTH)
    ) u_avg (
      .win     (lane_win),
      .weights (cfg.weights),
      .limit   (cfg.limit),
      .sample  ($signed(s1_pose_r[c])),
      .avg     (avg[c]),
      .in_bound(comp_in_bound[c])
    );
  end

  assign all_in_bound = &comp_in_bound;

  // pick raw or smoothed pose and the outcome code
  always_comb begin
    if (!s1_sole_r) begin
      out_pose_nxt    = s1_pose_r;
      out_outcome_nxt = phs_pkg::OUTCOME_PASS;
    end else if (all_in_bound) begin
      out_pose_nxt    = avg;
      out_outcome_nxt = phs_pkg::OUTCOME_SMOOTH;
    end else begin
      out_pose_nxt    = s1_pose_r;
      out_outcome_nxt = phs_pkg::OUTCOME_OUTLIER;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_pose_r    <= out_pose_nxt;
      out_outcome_r <= out_outcome_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = TDATA_W'(out_pose_r);
  assign out_tuser  = out_outcome_r;

`ifndef NO_ASSERTIONS
  a_pass_raw: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && !s1_sole_r) |=>
      (out_tuser == phs_pkg::OUTCOME_PASS && out_pose_r == $past(s1_pose_r)))
    else $error("non-sole beat not passed through unchanged");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_tready) |-> !adv)
    else $error("result register overwritten while stalled");

  a_accept_loads: assert property (@(posedge clk) disable iff (!rst_n)
    in_beat |=> s1_valid_r)
    else $error("accepted beat lost before the input register");

  a_reset_quiet: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_tvalid && in_tready))
    else $error("handshake active right after reset");
`endif

endmodule
